>>> design/utf8d_pkg.sv
// Package for the UTF-8 decoder with replacement.
// Holds the constants, the lead byte decode function and the types shared by
// the step logic, the output burst stage and the top level.
package utf8d_pkg;

  localparam int ByteW     = 8;
  localparam int CpW       = 21;
  localparam int CntW      = 3;
  localparam int LenW      = 3;
  localparam int HeldW     = 2;
  localparam int TdataOutW = 24;

  localparam logic [CntW-1:0] MaxResults = 3'd4;

  localparam logic [CpW-1:0] ReplChar  = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2      = 21'h000080;
  localparam logic [CpW-1:0] Min3      = 21'h000800;
  localparam logic [CpW-1:0] Min4      = 21'h010000;

  localparam logic [ByteW-1:0] AsciiTop = 8'h80;
  localparam logic [ByteW-1:0] Lead2Lo  = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Hi  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo  = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi  = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo  = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi  = 8'hF4;

  localparam logic [1:0] ContTag = 2'b10;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;

  typedef struct packed {
    logic            is_ascii;
    logic            is_multi;
    logic [LenW-1:0] len;
    logic [CpW-1:0]  payload;
  } lead_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [CpW-1:0]  cp;
    logic            repl;
  } burst_t;

  function automatic lead_t lead_decode(input logic [ByteW-1:0] b);
    lead_t l;
    l = '0;
    if (b < AsciiTop) begin
      l.is_ascii = 1'b1;
      l.payload  = {{(CpW-ByteW){1'b0}}, b};
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      l.is_multi = 1'b1;
      l.len      = Len2;
      l.payload  = {{(CpW-5){1'b0}}, b[4:0]};
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      l.is_multi = 1'b1;
      l.len      = Len3;
      l.payload  = {{(CpW-4){1'b0}}, b[3:0]};
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      l.is_multi = 1'b1;
      l.len      = Len4;
      l.payload  = {{(CpW-3){1'b0}}, b[2:0]};
    end
    return l;
  endfunction

endpackage

>>> design/utf8d_step.sv
// Sequence state and per-byte decode for the UTF-8 decoder.
// Turns the registered byte and the pending sequence into a result burst.
// Depends on utf8d_pkg.
module utf8d_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [utf8d_pkg::ByteW-1:0]  in_byte,
  input  logic                         end_of_text,
  output utf8d_pkg::burst_t            result
);

  logic [utf8d_pkg::LenW-1:0]  expected_length;
  logic [utf8d_pkg::LenW-1:0]  expected_length_next;
  logic [utf8d_pkg::HeldW-1:0] bytes_held;
  logic [utf8d_pkg::HeldW-1:0] bytes_held_next;
  logic [utf8d_pkg::CpW-1:0]   partial_value;
  logic [utf8d_pkg::CpW-1:0]   partial_value_next;

  utf8d_pkg::lead_t           ld;
  utf8d_pkg::burst_t          lead_res;
  logic                       lead_opens;
  logic                       active;
  logic                       is_cont;
  logic [utf8d_pkg::LenW-1:0] held1;
  logic [utf8d_pkg::CpW-1:0]  val;
  logic                       val_ok;

  always_comb begin
    ld         = utf8d_pkg::lead_decode(in_byte);
    lead_opens = ld.is_multi && !end_of_text;
    lead_res   = '{count: 3'd0, cp: utf8d_pkg::ReplChar, repl: 1'b1};
    if (ld.is_ascii) begin
      lead_res = '{count: 3'd1, cp: ld.payload, repl: 1'b0};
    end else if (!lead_opens) begin
      lead_res.count = 3'd1;
    end

    active  = expected_length >= utf8d_pkg::Len2 && expected_length <= utf8d_pkg::Len4;
    is_cont = in_byte[7:6] == utf8d_pkg::ContTag;
    held1   = {1'b0, bytes_held} + 3'd1;
    val     = {partial_value[utf8d_pkg::CpW-7:0], in_byte[5:0]};

    val_ok = 1'b1;
    if (val > utf8d_pkg::MaxScalar) val_ok = 1'b0;
    if (val >= utf8d_pkg::SurrLo && val <= utf8d_pkg::SurrHi) val_ok = 1'b0;
    if (expected_length == utf8d_pkg::Len2 && val < utf8d_pkg::Min2) val_ok = 1'b0;
    if (expected_length == utf8d_pkg::Len3 && val < utf8d_pkg::Min3) val_ok = 1'b0;
    if (expected_length == utf8d_pkg::Len4 && val < utf8d_pkg::Min4) val_ok = 1'b0;

    expected_length_next = utf8d_pkg::LenNone;
    bytes_held_next      = '0;
    partial_value_next   = '0;
    result               = '{count: 3'd0, cp: utf8d_pkg::ReplChar, repl: 1'b1};

    if (!active) begin
      result = lead_res;
      if (lead_opens) begin
        expected_length_next = ld.len;
        bytes_held_next      = 2'd1;
        partial_value_next   = ld.payload;
      end
    end else if (is_cont) begin
      if (held1 >= expected_length) begin
        if (val_ok) begin
          result = '{count: 3'd1, cp: val, repl: 1'b0};
        end else begin
          result.count = expected_length;
        end
      end else if (end_of_text) begin
        result.count = held1;
      end else begin
        expected_length_next = expected_length;
        bytes_held_next      = held1[utf8d_pkg::HeldW-1:0];
        partial_value_next   = val;
      end
    end else begin
      result.count = {1'b0, bytes_held} + lead_res.count;
      if (lead_res.count != 3'd0) begin
        result.cp   = lead_res.cp;
        result.repl = lead_res.repl;
      end
      if (lead_opens) begin
        expected_length_next = ld.len;
        bytes_held_next      = 2'd1;
        partial_value_next   = ld.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= utf8d_pkg::LenNone;
      bytes_held      <= '0;
      partial_value   <= '0;
    end else if (advance) begin
      expected_length <= expected_length_next;
      bytes_held      <= bytes_held_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule

>>> design/utf8d_burst.sv
// Output burst register of the UTF-8 decoder.
// Holds one byte's results and plays them out one word per handshake.
// Depends on utf8d_pkg.
module utf8d_burst (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  utf8d_pkg::burst_t                load_res,
  output logic                             free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [utf8d_pkg::TdataOutW-1:0]  m_tdata,   // [20:0] code_point, zero fill above
  output logic                             m_tuser,   // [0] replaced
  output logic                             m_tlast    // run_last
);

  logic [utf8d_pkg::CntW-1:0] remaining;
  logic [utf8d_pkg::CpW-1:0]  last_cp;
  logic                       last_repl;

  assign m_tvalid = remaining != '0;
  assign m_tlast  = remaining == 3'd1;
  assign free     = !m_tvalid || (m_tlast && m_tready);
  assign m_tdata  = {{(utf8d_pkg::TdataOutW-utf8d_pkg::CpW){1'b0}},
                     m_tlast ? last_cp : utf8d_pkg::ReplChar};
  assign m_tuser  = m_tlast ? last_repl : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= load_res.count;
    end else if (m_tvalid && m_tready) begin
      remaining <= remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_cp   <= load_res.cp;
      last_repl <= load_res.repl;
    end
  end

endmodule

>>> design/utf8_decoder_with_replacement.sv
// Top level of the UTF-8 decoder with replacement.
// Input register, step logic and output burst register.
// Depends on utf8d_pkg, utf8d_step and utf8d_burst.
//
// Usage:
//   Slave side takes one text byte per word: s_tdata holds the byte,
//   s_tlast marks the final byte of the text.
//   Master side gives one code point per word: m_tdata[20:0] holds it,
//   m_tuser is set when it is U+FFFD standing for invalid input, and m_tlast
//   marks the final code point caused by one input byte.
//   A byte that only extends a pending sequence gives no word.
// Timing:
//   A byte is accepted into the input register, decoded by the combinational step
//   logic, and its results are loaded into the output burst register once it is free.
//   One byte per cycle is sustained while every byte gives at most one code
//   point and m_tready is high; a byte giving several code points holds the
//   output burst register until the last is taken and the input waits for it.
//   When m_tready is low the burst register holds, then the input register
//   fills and s_tready drops.
// Reset:
//   rst clears the pending sequence and both registers; no word is pending.
module utf8_decoder_with_replacement (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [utf8d_pkg::ByteW-1:0]      s_tdata,   // [7:0] in_byte
  input  logic                             s_tlast,   // end_of_text
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [utf8d_pkg::TdataOutW-1:0]  m_tdata,   // [20:0] code_point, zero fill above
  output logic                             m_tuser,   // [0] replaced
  output logic                             m_tlast    // run_last
);

  logic                        in_valid;
  logic [utf8d_pkg::ByteW-1:0] in_byte;
  logic                        in_eot;
  logic                        free;
  logic                        load;
  utf8d_pkg::burst_t           step_res;

  assign load     = in_valid && free;
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  utf8d_step u_step (
    .clk         (clk),
    .rst         (rst),
    .advance     (load),
    .in_byte     (in_byte),
    .end_of_text (in_eot),
    .result      (step_res)
  );

  utf8d_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .load_res (step_res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    load |-> step_res.count <= utf8d_pkg::MaxResults)
    else $error("burst longer than four results");

  a_only_last_plain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser)
    else $error("non-final result is not a replacement");

  a_plain_is_scalar: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      m_tdata[20:0] <= utf8d_pkg::MaxScalar &&
      (m_tdata[20:0] < utf8d_pkg::SurrLo || m_tdata[20:0] > utf8d_pkg::SurrHi))
    else $error("decoded value is not a scalar value");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_valid && !free |=> in_valid && $stable(in_byte))
    else $error("input register lost a byte while output blocked");

endmodule

>>> test/utf8_decoder_with_replacement_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_decoder_with_replacement: streams UTF-8 text bytes
// and checks every decoded code point against an in-bench decoder.
// Depends on utf8d_pkg and the decoder RTL.
module utf8_decoder_with_replacement_tb;

  localparam int QuietLimit = 1000;
  localparam int TailCycles = 20;

  typedef struct packed {
    logic [utf8d_pkg::ByteW-1:0] data;
    logic                        eot;
  } text_byte_t;

  typedef struct packed {
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      repl;
    logic                      last;
  } cp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [utf8d_pkg::ByteW-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [utf8d_pkg::TdataOutW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  text_byte_t text_bytes[$];
  cp_word_t   pending_cps[$];
  cp_word_t   step_words[$];
  int         bytes_queued = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  logic       steady = 1'b0;

  logic [utf8d_pkg::LenW-1:0]  seq_len = utf8d_pkg::LenNone;
  logic [utf8d_pkg::HeldW-1:0] seq_held = '0;
  logic [utf8d_pkg::CpW-1:0]   seq_value = '0;

  utf8_decoder_with_replacement i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void put_cp(input logic [utf8d_pkg::CpW-1:0] cp, input logic repl);
    cp_word_t w;
    if (step_words.size() < int'(utf8d_pkg::MaxResults)) begin
      w.cp   = cp;
      w.repl = repl;
      w.last = 1'b0;
      step_words = {step_words, w};
    end
  endfunction

  function automatic void put_failed_run(input int conts);
    int i;
    put_cp(utf8d_pkg::ReplChar, 1'b1);
    for (i = 0; i < conts && i < 3; i++) put_cp(utf8d_pkg::ReplChar, 1'b1);
  endfunction

  function automatic void clear_run();
    seq_len   = utf8d_pkg::LenNone;
    seq_held  = '0;
    seq_value = '0;
  endfunction

  function automatic void start_run(input logic [utf8d_pkg::LenW-1:0] len,
                                    input logic [utf8d_pkg::CpW-1:0] payload,
                                    input logic eot);
    if (eot) begin
      put_cp(utf8d_pkg::ReplChar, 1'b1);
    end else begin
      seq_len   = len;
      seq_held  = 2'd1;
      seq_value = payload;
    end
  endfunction

  function automatic void open_lead(input logic [utf8d_pkg::ByteW-1:0] b, input logic eot);
    if (b < utf8d_pkg::AsciiTop) begin
      put_cp({{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, b}, 1'b0);
    end else if (b >= utf8d_pkg::Lead2Lo && b <= utf8d_pkg::Lead2Hi) begin
      start_run(utf8d_pkg::Len2, {{(utf8d_pkg::CpW-5){1'b0}}, b[4:0]}, eot);
    end else if (b >= utf8d_pkg::Lead3Lo && b <= utf8d_pkg::Lead3Hi) begin
      start_run(utf8d_pkg::Len3, {{(utf8d_pkg::CpW-4){1'b0}}, b[3:0]}, eot);
    end else if (b >= utf8d_pkg::Lead4Lo && b <= utf8d_pkg::Lead4Hi) begin
      start_run(utf8d_pkg::Len4, {{(utf8d_pkg::CpW-3){1'b0}}, b[2:0]}, eot);
    end else begin
      put_cp(utf8d_pkg::ReplChar, 1'b1);
    end
  endfunction

  function automatic logic scalar_ok(input logic [utf8d_pkg::CpW-1:0] cp,
                                     input logic [utf8d_pkg::LenW-1:0] len);
    if (cp > utf8d_pkg::MaxScalar) return 1'b0;
    if (cp >= utf8d_pkg::SurrLo && cp <= utf8d_pkg::SurrHi) return 1'b0;
    if (len == utf8d_pkg::Len2 && cp < utf8d_pkg::Min2) return 1'b0;
    if (len == utf8d_pkg::Len3 && cp < utf8d_pkg::Min3) return 1'b0;
    if (len == utf8d_pkg::Len4 && cp < utf8d_pkg::Min4) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void decode_byte(input logic [utf8d_pkg::ByteW-1:0] b, input logic eot);
    logic [utf8d_pkg::LenW-1:0] held;
    logic [utf8d_pkg::LenW-1:0] len;
    logic [utf8d_pkg::CpW-1:0]  val;
    int                         conts;
    step_words.delete();
    len = seq_len;
    if (len < utf8d_pkg::Len2 || len > utf8d_pkg::Len4) begin
      clear_run();
      open_lead(b, eot);
    end else if (b[7:6] == utf8d_pkg::ContTag) begin
      held = {1'b0, seq_held} + 3'd1;
      val  = {seq_value[utf8d_pkg::CpW-7:0], b[5:0]};
      if (held >= len) begin
        clear_run();
        if (scalar_ok(val, len)) put_cp(val, 1'b0);
        else put_failed_run(int'(len) - 1);
      end else if (eot) begin
        clear_run();
        put_failed_run(int'(held) - 1);
      end else begin
        seq_held  = held[utf8d_pkg::HeldW-1:0];
        seq_value = val;
      end
    end else begin
      conts = (seq_held != 0) ? int'(seq_held) - 1 : 0;
      clear_run();
      put_failed_run(conts);
      open_lead(b, eot);
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    foreach (step_words[i]) pending_cps = {pending_cps, step_words[i]};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (text_bytes.size() > 0 && (steady || $urandom_range(99) >= 27)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= text_bytes[0].data;
          s_tlast  <= text_bytes[0].eot;
          void'(text_bytes.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cp_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_cps.size() == 0) begin
          $display("%0t: unexpected word: expected none got tdata %06h tuser %0b tlast %0b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = pending_cps.pop_front();
          if (m_tdata !== {{(utf8d_pkg::TdataOutW-utf8d_pkg::CpW){1'b0}}, want.cp}) begin
            $display("%0t: code point mismatch: expected %06h got %06h",
                     $time, want.cp, m_tdata);
            mismatches++;
          end
          if (m_tuser !== want.repl) begin
            $display("%0t: replaced flag mismatch: expected %0b got %0b",
                     $time, want.repl, m_tuser);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last flag mismatch: expected %0b got %0b",
                     $time, want.last, m_tlast);
            mismatches++;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("utf8_decoder_with_replacement regression: fail");
      $finish;
    end
  end

  task automatic push_byte(input logic [utf8d_pkg::ByteW-1:0] b, input logic eot);
    text_byte_t w;
    w.data = b;
    w.eot  = eot;
    text_bytes = {text_bytes, w};
    bytes_queued++;
  endtask

  task automatic push_cont(input logic eot);
    push_byte({utf8d_pkg::ContTag, 6'($urandom_range(63))}, eot);
  endtask

  task automatic push_scalar(input logic [utf8d_pkg::CpW-1:0] cp, input logic eot);
    if (cp < utf8d_pkg::Min2) begin
      push_byte(cp[7:0], eot);
    end else if (cp < utf8d_pkg::Min3) begin
      push_byte({3'b110, cp[10:6]}, 1'b0);
      push_byte({utf8d_pkg::ContTag, cp[5:0]}, eot);
    end else if (cp < utf8d_pkg::Min4) begin
      push_byte({4'b1110, cp[15:12]}, 1'b0);
      push_byte({utf8d_pkg::ContTag, cp[11:6]}, 1'b0);
      push_byte({utf8d_pkg::ContTag, cp[5:0]}, eot);
    end else begin
      push_byte({5'b11110, cp[20:18]}, 1'b0);
      push_byte({utf8d_pkg::ContTag, cp[17:12]}, 1'b0);
      push_byte({utf8d_pkg::ContTag, cp[11:6]}, 1'b0);
      push_byte({utf8d_pkg::ContTag, cp[5:0]}, eot);
    end
  endtask

  function automatic logic [utf8d_pkg::ByteW-1:0] random_lead(input int len);
    case (len)
      2:       return 8'($urandom_range(utf8d_pkg::Lead2Hi, utf8d_pkg::Lead2Lo));
      3:       return 8'($urandom_range(utf8d_pkg::Lead3Hi, utf8d_pkg::Lead3Lo));
      default: return 8'($urandom_range(utf8d_pkg::Lead4Hi, utf8d_pkg::Lead4Lo));
    endcase
  endfunction

  task automatic push_random_run();
    int                          pick;
    int                          len;
    int                          n;
    int                          i;
    int                          cp;
    logic                        eot;
    logic [utf8d_pkg::ByteW-1:0] b;
    pick = $urandom_range(99);
    eot  = ($urandom_range(7) == 0);
    len  = $urandom_range(4, 2);
    if (pick < 45) begin
      case ($urandom_range(3))
        0: cp = $urandom_range(8'h7F);
        1: cp = $urandom_range(16'h7FF, 16'h80);
        2: begin
          cp = $urandom_range(16'hFFFF, 16'h800);
          if (cp >= utf8d_pkg::SurrLo && cp <= utf8d_pkg::SurrHi) cp = cp - 16'h1000;
        end
        default: cp = $urandom_range(utf8d_pkg::MaxScalar, utf8d_pkg::Min4);
      endcase
      push_scalar(cp[utf8d_pkg::CpW-1:0], eot);
    end else if (pick < 60) begin
      case ($urandom_range(3))
        0: begin
          push_byte(utf8d_pkg::Lead3Lo, 1'b0);
          push_byte({3'b100, 5'($urandom_range(31))}, 1'b0);
          push_cont(eot);
        end
        1: begin
          push_byte(8'hED, 1'b0);
          push_byte({3'b101, 5'($urandom_range(31))}, 1'b0);
          push_cont(eot);
        end
        2: begin
          push_byte(utf8d_pkg::Lead4Lo, 1'b0);
          push_byte({4'b1000, 4'($urandom_range(15))}, 1'b0);
          push_cont(1'b0);
          push_cont(eot);
        end
        default: begin
          push_byte(utf8d_pkg::Lead4Hi, 1'b0);
          push_byte(8'($urandom_range(8'hBF, 8'h90)), 1'b0);
          push_cont(1'b0);
          push_cont(eot);
        end
      endcase
    end else if (pick < 75) begin
      push_byte(random_lead(len), 1'b0);
      n = $urandom_range(len - 2);
      for (i = 0; i < n; i++) push_cont(1'b0);
      b = 8'($urandom_range(255));
      if (b[7:6] == utf8d_pkg::ContTag) b[6] = 1'b1;
      push_byte(b, eot);
    end else if (pick < 82) begin
      n = $urandom_range(len - 2);
      push_byte(random_lead(len), n == 0);
      for (i = 0; i < n; i++) push_cont(i == n - 1);
    end else begin
      push_byte(8'($urandom_range(255)), eot);
    end
  endtask

  task automatic drain();
    while (text_bytes.size() > 0 || s_tvalid || pending_cps.size() > 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int target;
    target = bytes_queued + count;
    while (bytes_queued < target) push_random_run();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hE0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hED, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hE1, 1'b1);
    push_byte(8'hE1, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'hF1, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    drain();

    run_random(90);
    steady = 1'b1;
    run_random(80);
    steady = 1'b0;
    run_random(80);

    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending_cps.size() == 0) begin
      $display("utf8_decoder_with_replacement regression: pass");
    end else begin
      $display("utf8_decoder_with_replacement regression: fail");
    end
    $finish;
  end

endmodule
